@@ hdl/ppdr_pkg.sv @@
package ppdr_pkg;

    // cordic iteration count, legal range 8 to 24
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W   = 5;

    // cordic vector and angle widths
    localparam int XY_W = 20;
    localparam int Z_W  = 33;

    // start vector length, 2^16 over the cordic gain
    localparam logic signed [XY_W-1:0] CORDIC_START = XY_W'(39797);

    // shared multiplier operand widths
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = 56;

    // configuration register indexes
    localparam logic [1:0] REG_START_X       = 2'd0;
    localparam logic [1:0] REG_START_Y       = 2'd1;
    localparam logic [1:0] REG_START_HEADING = 2'd2;

    // request kinds
    localparam logic REQ_VELOCITY = 1'b0;
    localparam logic REQ_STATE    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_ANG,
        ST_MUL_LIN,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        MUL_ANG,
        MUL_LIN,
        MUL_X,
        MUL_Y
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              load_dt;
        logic              apply_state;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              upd_heading;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              add_x;
        logic              add_y;
        logic              load_out;
        logic              moved;
    } cmd_t;

    typedef struct packed {
        logic req_state;
        logic active;
    } stat_t;

    typedef struct packed {
        logic        wr_x;
        logic        wr_y;
        logic        wr_h;
        logic [31:0] data;
    } cfg_wr_t;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [31:0] atan_value(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ppdr_ctrl.sv @@
module ppdr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  ppdr_pkg::stat_t stat,
    output ppdr_pkg::cmd_t  cmd
);

    ppdr_pkg::state_t                state_reg, state_next;
    logic [ppdr_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            moved_reg, moved_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            step_last;
    logic                            out_free;

    assign step_last = (step_reg == ppdr_pkg::STEP_W'(ppdr_pkg::CORDIC_STEPS - 1));
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppdr_pkg::ST_IDLE;
            step_reg      <= '0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppdr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ppdr_pkg::ST_DECODE;
            end
            ppdr_pkg::ST_DECODE:
            begin
                if (!stat.req_state && stat.active)
                    state_next = ppdr_pkg::ST_MUL_ANG;
                else
                    state_next = ppdr_pkg::ST_RESULT;
            end
            ppdr_pkg::ST_MUL_ANG:     state_next = ppdr_pkg::ST_MUL_LIN;
            ppdr_pkg::ST_MUL_LIN:     state_next = ppdr_pkg::ST_CORDIC_INIT;
            ppdr_pkg::ST_CORDIC_INIT: state_next = ppdr_pkg::ST_CORDIC;
            ppdr_pkg::ST_CORDIC:
            begin
                if (step_last)
                    state_next = ppdr_pkg::ST_MUL_X;
            end
            ppdr_pkg::ST_MUL_X:       state_next = ppdr_pkg::ST_MUL_Y;
            ppdr_pkg::ST_MUL_Y:       state_next = ppdr_pkg::ST_ADD_Y;
            ppdr_pkg::ST_ADD_Y:       state_next = ppdr_pkg::ST_RESULT;
            ppdr_pkg::ST_RESULT:
            begin
                if (out_free)
                    state_next = ppdr_pkg::ST_IDLE;
            end
            default:                  state_next = ppdr_pkg::ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = ppdr_pkg::MUL_ANG;
        cmd.step_idx   = step_reg;
        cmd.moved      = moved_reg;
        s_tready       = 1'b0;
        step_next      = step_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ppdr_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ppdr_pkg::ST_DECODE:
            begin
                cmd.load_dt     = 1'b1;
                cmd.apply_state = stat.req_state;
                moved_next      = !stat.req_state && stat.active;
            end
            ppdr_pkg::ST_MUL_ANG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppdr_pkg::MUL_ANG;
            end
            ppdr_pkg::ST_MUL_LIN:
            begin
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = ppdr_pkg::MUL_LIN;
                cmd.upd_heading = 1'b1;
            end
            ppdr_pkg::ST_CORDIC_INIT:
            begin
                cmd.cordic_init = 1'b1;
                step_next       = '0;
            end
            ppdr_pkg::ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 1'b1;
            end
            ppdr_pkg::ST_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppdr_pkg::MUL_X;
            end
            ppdr_pkg::ST_MUL_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ppdr_pkg::MUL_Y;
                cmd.add_x   = 1'b1;
            end
            ppdr_pkg::ST_ADD_Y:
            begin
                cmd.add_y = 1'b1;
            end
            ppdr_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ hdl/ppdr_dpath.sv @@
module ppdr_dpath
(
    input  logic              clk,
    input  logic              rst_n,
    input  ppdr_pkg::cmd_t    cmd,
    input  ppdr_pkg::cfg_wr_t cfg_wr,
    output ppdr_pkg::stat_t   stat,
    input  logic              in_req_type,
    input  logic [31:0]       in_now_time,
    input  logic [23:0]       in_lin_speed,
    input  logic [23:0]       in_turn_rate,
    input  logic              in_active_now,
    output logic [31:0]       out_pos_x,
    output logic [31:0]       out_pos_y,
    output logic [15:0]       out_heading,
    output logic              out_moved
);

    // latched input word
    logic                 req_reg;
    logic [31:0]          now_reg;
    logic signed [23:0]   spd_reg;
    logic signed [23:0]   rate_reg;
    logic                 act_in_reg;

    // pose state
    logic [31:0]          x_pos_reg;
    logic [31:0]          y_pos_reg;
    logic [15:0]          heading_reg;
    logic                 active_reg;
    logic [31:0]          last_time_reg;

    // working registers
    logic [31:0]                           dt_reg;
    logic signed [39:0]                    dlin_reg;
    logic [ppdr_pkg::PROD_W-1:0]           prod_reg;
    logic signed [ppdr_pkg::XY_W-1:0]      cx_reg;
    logic signed [ppdr_pkg::XY_W-1:0]      cy_reg;
    logic signed [ppdr_pkg::Z_W-1:0]       cz_reg;

    // shared multiplier
    logic signed [ppdr_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [ppdr_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [ppdr_pkg::MUL_A_W+ppdr_pkg::MUL_B_W-1:0] mul_p;

    // cordic start and step terms
    logic                                  flip;
    logic [31:0]                           ang32;
    logic signed [ppdr_pkg::XY_W-1:0]      sh_x;
    logic signed [ppdr_pkg::XY_W-1:0]      sh_y;
    logic signed [ppdr_pkg::Z_W-1:0]       atan_z;

    always_comb
    begin
        case (cmd.mul_sel)
            ppdr_pkg::MUL_ANG:
            begin
                mul_a = ppdr_pkg::MUL_A_W'({1'b0, dt_reg});
                mul_b = ppdr_pkg::MUL_B_W'(rate_reg);
            end
            ppdr_pkg::MUL_LIN:
            begin
                mul_a = ppdr_pkg::MUL_A_W'({1'b0, dt_reg});
                mul_b = ppdr_pkg::MUL_B_W'(spd_reg);
            end
            ppdr_pkg::MUL_X:
            begin
                mul_a = ppdr_pkg::MUL_A_W'(dlin_reg);
                mul_b = ppdr_pkg::MUL_B_W'(cx_reg);
            end
            ppdr_pkg::MUL_Y:
            begin
                mul_a = ppdr_pkg::MUL_A_W'(dlin_reg);
                mul_b = ppdr_pkg::MUL_B_W'(cy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // left half plane is turned by half a turn
    assign flip   = (heading_reg[15:14] == 2'b01) || (heading_reg[15:14] == 2'b10);
    assign ang32  = {heading_reg[15] ^ flip, heading_reg[14:0], 16'b0};
    assign sh_x   = cx_reg >>> cmd.step_idx;
    assign sh_y   = cy_reg >>> cmd.step_idx;
    assign atan_z = ppdr_pkg::Z_W'(ppdr_pkg::atan_value(
                        ppdr_pkg::ATAN_IDX_W'(cmd.step_idx)));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= in_req_type;
            now_reg    <= in_now_time;
            spd_reg    <= in_lin_speed;
            rate_reg   <= in_turn_rate;
            act_in_reg <= in_active_now;
        end
        if (cmd.load_dt)
            dt_reg <= now_reg - last_time_reg;
        if (cmd.mul_en)
            prod_reg <= mul_p[ppdr_pkg::PROD_W-1:0];
        if (cmd.cordic_init)
        begin
            dlin_reg <= prod_reg[55:16];
            cx_reg   <= flip ? -ppdr_pkg::CORDIC_START : ppdr_pkg::CORDIC_START;
            cy_reg   <= '0;
            cz_reg   <= ppdr_pkg::Z_W'(signed'(ang32));
        end
        else if (cmd.cordic_step)
        begin
            if (!cz_reg[ppdr_pkg::Z_W-1])
            begin
                cx_reg <= cx_reg - sh_y;
                cy_reg <= cy_reg + sh_x;
                cz_reg <= cz_reg - atan_z;
            end
            else
            begin
                cx_reg <= cx_reg + sh_y;
                cy_reg <= cy_reg - sh_x;
                cz_reg <= cz_reg + atan_z;
            end
        end
        if (cmd.load_out)
        begin
            out_pos_x   <= x_pos_reg;
            out_pos_y   <= y_pos_reg;
            out_heading <= heading_reg;
            out_moved   <= cmd.moved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg     <= '0;
            y_pos_reg     <= '0;
            heading_reg   <= '0;
            active_reg    <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (cfg_wr.wr_x)
                x_pos_reg <= cfg_wr.data;
            else if (cmd.add_x)
                x_pos_reg <= x_pos_reg + prod_reg[47:16];
            if (cfg_wr.wr_y)
                y_pos_reg <= cfg_wr.data;
            else if (cmd.add_y)
                y_pos_reg <= y_pos_reg + prod_reg[47:16];
            if (cfg_wr.wr_h)
                heading_reg <= cfg_wr.data[15:0];
            else if (cmd.upd_heading)
                heading_reg <= heading_reg + prod_reg[31:16];
            if (cmd.apply_state)
            begin
                active_reg <= act_in_reg;
                if (act_in_reg && !active_reg)
                    last_time_reg <= now_reg;
            end
            else if (cmd.upd_heading)
                last_time_reg <= now_reg;
        end
    end

    assign stat.req_state = (req_reg == ppdr_pkg::REQ_STATE);
    assign stat.active    = active_reg;

endmodule

@@ hdl/planar_pose_dead_reckoning.sv @@
// planar pose dead reckoning: keeps x, y (signed q16.16 m) and a 16-bit binary heading
// and integrates them from velocity command words. a velocity word taken while active
// adds dt * turn_rate to the heading, then moves x and y by dt * lin_speed along the
// cosine and sine of the new heading; a state word (tuser = 1) sets the active flag and
// reloads the last time on a change to active. every input word returns one pose word.
// an active velocity word runs through decode, the iterative cordic (one rotation per
// cycle) and the single shared multiplier used four times in turn before its result;
// any other word goes from decode straight to the result.
// the next input word is taken once the current result sits in the output register.
// writing start_x, start_y or start_heading also loads that part of the pose at once.
module planar_pose_dead_reckoning
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // now_time[31:0], lin_speed[55:32], turn_rate[79:56],
                                   // active_now[80], zero[87:81]
    input  logic        s_tuser,   // req_type[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading_out[79:64],
                                   // pose_moved[80], zero[87:81]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppdr_pkg::cmd_t    cmd;
    ppdr_pkg::stat_t   stat;
    ppdr_pkg::cfg_wr_t cfg_wr;

    // start registers, kept here for read back
    logic [31:0] start_x_reg;
    logic [31:0] start_y_reg;
    logic [15:0] start_heading_reg;

    logic        apb_write;
    logic [1:0]  reg_idx;

    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading_out;
    logic        pose_moved;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[3:2];

    // write strobes, out-of-range indexes fall through
    assign cfg_wr.wr_x = apb_write && (reg_idx == ppdr_pkg::REG_START_X);
    assign cfg_wr.wr_y = apb_write && (reg_idx == ppdr_pkg::REG_START_Y);
    assign cfg_wr.wr_h = apb_write && (reg_idx == ppdr_pkg::REG_START_HEADING);
    assign cfg_wr.data = pwdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end
        else
        begin
            if (cfg_wr.wr_x)
                start_x_reg <= pwdata;
            if (cfg_wr.wr_y)
                start_y_reg <= pwdata;
            if (cfg_wr.wr_h)
                start_heading_reg <= pwdata[15:0];
        end
    end

    // read back mux
    always_comb
    begin
        case (reg_idx)
            ppdr_pkg::REG_START_X:       prdata = start_x_reg;
            ppdr_pkg::REG_START_Y:       prdata = start_y_reg;
            ppdr_pkg::REG_START_HEADING: prdata = {16'b0, start_heading_reg};
            default:                     prdata = '0;
        endcase
    end

    // sequencer: walks decode, multiplies, cordic steps and result hand-off
    ppdr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pose state, shared multiplier, cordic and output register
    ppdr_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr        (cfg_wr),
        .stat          (stat),
        .in_req_type   (s_tuser),
        .in_now_time   (s_tdata[31:0]),
        .in_lin_speed  (s_tdata[55:32]),
        .in_turn_rate  (s_tdata[79:56]),
        .in_active_now (s_tdata[80]),
        .out_pos_x     (pos_x),
        .out_pos_y     (pos_y),
        .out_heading   (heading_out),
        .out_moved     (pose_moved)
    );

    assign m_tdata = {7'b0, pose_moved, heading_out, pos_y, pos_x};

endmodule
